[hdl/rsg_pkg.sv]
package rsg_pkg;

    localparam int MAX_STEPS = 16;
    localparam int TBL_DEPTH = MAX_STEPS + 1;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);
    localparam int TIME_W    = 24;
    localparam int VAL_W     = 24;
    localparam int SEG_W     = 5;
    localparam int SLOPE_W   = 48;
    localparam int DIV_STEPS = SLOPE_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_START = 2'd1,
        MODE_TICK  = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_CUR,
        S_RD_NXT,
        S_CHECK,
        S_DIV,
        S_SLOPE,
        S_PREP,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_OUT
    } state_t;

    typedef struct packed {
        mode_t                     mode;
        logic [SEG_W-1:0]          point_index;
        logic [TIME_W-1:0]         point_time;
        logic signed [VAL_W-1:0]   point_value;
        logic signed [VAL_W-1:0]   start_value;
    } rsg_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]   setpoint;
        logic [SEG_W-1:0]          segment;
        logic                      at_end;
    } rsg_out_t;

endpackage

[hdl/ramp_soak_setpoint_generator.sv]
// a tick steps through S_RD_CUR, S_RD_NXT, S_CHECK, S_PREP, S_MUL_LO, S_MUL_HI,
// S_SUM and S_OUT, with S_DIV (bit-serial slope divider) and S_SLOPE after S_CHECK
// when it moves to a new segment; done is registered from S_OUT; busy is high and
// blocks new transfers until the result is out; writes and starts never raise busy
// reset: async active low, clears time, segment, slope and anchor; the point table
// holds nothing defined until written; the receiver cannot stall the result strobe
module ramp_soak_setpoint_generator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rsg_pkg::rsg_in_t  cmd,
    output logic              done,
    output rsg_pkg::rsg_out_t result
);
    import rsg_pkg::*;

    localparam logic [SEG_W-1:0]  SEG_MAX  = SEG_W'(MAX_STEPS);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    state_t state_reg, state_next;

    // point table
    logic [TIME_W-1:0]       time_mem  [TBL_DEPTH];
    logic signed [VAL_W-1:0] value_mem [TBL_DEPTH];
    logic [TIME_W-1:0]       rd_t_reg;
    logic signed [VAL_W-1:0] rd_v_reg;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       wr_addr;
    logic                    t_we;
    logic                    v_we;
    logic signed [VAL_W-1:0] v_wdata;

    // profile state
    logic [TIME_W-1:0]         elapsed_reg;
    logic [SEG_W-1:0]          seg_reg;
    logic signed [SLOPE_W-1:0] slope_reg;
    logic [TIME_W-1:0]         anchor_t_reg;
    logic signed [VAL_W-1:0]   anchor_v_reg;
    logic                      at_end_reg;

    logic [TIME_W-1:0]       cur_t_reg;
    logic signed [VAL_W-1:0] cur_v_reg;

    // divider
    logic [SLOPE_W-1:0] div_quo_reg;
    logic [TIME_W-1:0]  div_rem_reg;
    logic [TIME_W-1:0]  div_den_reg;
    logic               div_neg_reg;
    logic [CNT_W-1:0]   div_cnt_reg;

    // multiplier path
    logic [SLOPE_W-1:0]   ms_reg;
    logic [TIME_W-1:0]    md_reg;
    logic                 neg_reg;
    logic [2*TIME_W-1:0]  prod_reg;
    logic [TIME_W:0]      acc_reg;
    logic signed [SLOPE_W+1:0] term_reg;

    logic     done_reg;
    rsg_out_t result_reg;

    logic                accept;
    logic [TIME_W-1:0]   mult_a;
    logic [2*TIME_W-1:0] product;
    logic [SEG_W-1:0]    seg_inc;

    logic                    reached;
    logic                    can_adv;
    logic signed [VAL_W:0]   dy;
    logic [VAL_W-1:0]        dy_mag;

    logic [TIME_W:0] div_sh;
    logic            div_ge;

    logic signed [TIME_W:0] d_diff;
    logic [SLOPE_W:0]       q_mag;
    logic signed [SLOPE_W+1:0] sp_sum;

    assign accept  = start && !busy;
    assign seg_inc = (seg_reg < SEG_MAX) ? SEG_W'(seg_reg + 1'b1) : seg_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd.mode == MODE_TICK)
                    state_next = S_RD_CUR;
            end
            S_RD_CUR: state_next = S_RD_NXT;
            S_RD_NXT: state_next = S_CHECK;
            S_CHECK:  state_next = (reached && can_adv) ? S_DIV : S_PREP;
            S_DIV:
            begin
                if (div_cnt_reg == CNT_LAST)
                    state_next = S_SLOPE;
            end
            S_SLOPE:  state_next = S_PREP;
            S_PREP:   state_next = S_MUL_LO;
            S_MUL_LO: state_next = S_MUL_HI;
            S_MUL_HI: state_next = S_SUM;
            S_SUM:    state_next = S_OUT;
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs and shared datapath controls
    always_comb
    begin
        busy    = (state_reg != S_IDLE);
        rd_addr = seg_inc;
        mult_a  = ms_reg[TIME_W-1:0];
        case (state_reg)
            S_RD_CUR: rd_addr = seg_reg;
            S_MUL_HI: mult_a  = ms_reg[SLOPE_W-1:TIME_W];
            default:
            begin
                rd_addr = seg_inc;
                mult_a  = ms_reg[TIME_W-1:0];
            end
        endcase
    end

    assign product = mult_a * md_reg;

    assign t_we    = accept && cmd.mode == MODE_WRITE && cmd.point_index <= SEG_MAX;
    assign v_we    = t_we || (accept && cmd.mode == MODE_START);
    assign v_wdata = (cmd.mode == MODE_START) ? cmd.start_value : cmd.point_value;
    assign wr_addr = (cmd.mode == MODE_START) ? '0 : cmd.point_index[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (t_we)
            time_mem[wr_addr] <= cmd.point_time;
        if (v_we)
            value_mem[wr_addr] <= v_wdata;
        rd_t_reg <= time_mem[rd_addr];
        rd_v_reg <= value_mem[rd_addr];
    end

    // segment check, rd_t_reg holds the next point here
    assign reached = elapsed_reg >= cur_t_reg;
    assign can_adv = (seg_reg < SEG_MAX) && (rd_t_reg > cur_t_reg);
    assign dy      = {rd_v_reg[VAL_W-1], rd_v_reg} - {cur_v_reg[VAL_W-1], cur_v_reg};
    assign dy_mag  = dy[VAL_W] ? VAL_W'(-dy) : dy[VAL_W-1:0];

    // restoring divide, one quotient bit a cycle
    assign div_sh = {div_rem_reg, div_quo_reg[SLOPE_W-1]};
    assign div_ge = div_sh >= {1'b0, div_den_reg};

    assign d_diff = {1'b0, elapsed_reg} - {1'b0, anchor_t_reg};
    assign q_mag  = {1'b0, prod_reg} + (SLOPE_W+1)'(acc_reg);
    assign sp_sum = (SLOPE_W+2)'(anchor_v_reg) + term_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            elapsed_reg  <= '0;
            seg_reg      <= '0;
            slope_reg    <= '0;
            anchor_t_reg <= '0;
            anchor_v_reg <= '0;
            div_cnt_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_OUT);
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && cmd.mode == MODE_START)
                    begin
                        elapsed_reg  <= '0;
                        seg_reg      <= '0;
                        slope_reg    <= '0;
                        anchor_t_reg <= '0;
                        anchor_v_reg <= cmd.start_value;
                    end
                end
                S_CHECK:
                begin
                    div_cnt_reg <= '0;
                    if (reached && can_adv)
                    begin
                        anchor_t_reg <= rd_t_reg;
                        anchor_v_reg <= rd_v_reg;
                        seg_reg      <= seg_inc;
                    end
                    else if (reached)
                    begin
                        slope_reg    <= '0;
                        anchor_t_reg <= cur_t_reg;
                        anchor_v_reg <= cur_v_reg;
                    end
                end
                S_DIV:
                    div_cnt_reg <= CNT_W'(div_cnt_reg + 1'b1);
                S_SLOPE:
                begin
                    if (!div_neg_reg)
                        slope_reg <= div_quo_reg[SLOPE_W-1]
                                     ? {1'b0, {(SLOPE_W-1){1'b1}}}
                                     : div_quo_reg;
                    else if (div_quo_reg[SLOPE_W-1] && |div_quo_reg[SLOPE_W-2:0])
                        slope_reg <= {1'b1, {(SLOPE_W-1){1'b0}}};
                    else
                        slope_reg <= -div_quo_reg;
                end
                S_OUT:
                begin
                    if (elapsed_reg != TIME_MAX)
                        elapsed_reg <= TIME_W'(elapsed_reg + 1'b1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_RD_NXT:
            begin
                cur_t_reg <= rd_t_reg;
                cur_v_reg <= rd_v_reg;
            end
            S_CHECK:
            begin
                at_end_reg  <= !can_adv;
                div_quo_reg <= {dy_mag, {TIME_W{1'b0}}};
                div_rem_reg <= '0;
                div_den_reg <= rd_t_reg - cur_t_reg;
                div_neg_reg <= dy[VAL_W];
            end
            S_DIV:
            begin
                div_rem_reg <= div_ge ? TIME_W'(div_sh - {1'b0, div_den_reg})
                                      : div_sh[TIME_W-1:0];
                div_quo_reg <= {div_quo_reg[SLOPE_W-2:0], div_ge};
            end
            S_SLOPE:
            begin
                // rd_t_reg now holds the point after the new segment
                at_end_reg <= (seg_reg >= SEG_MAX) || (rd_t_reg <= anchor_t_reg);
            end
            S_PREP:
            begin
                ms_reg  <= slope_reg[SLOPE_W-1] ? SLOPE_W'(-slope_reg) : slope_reg;
                md_reg  <= d_diff[TIME_W] ? TIME_W'(-d_diff) : d_diff[TIME_W-1:0];
                neg_reg <= slope_reg[SLOPE_W-1] ^ d_diff[TIME_W];
            end
            S_MUL_LO:
                prod_reg <= product;
            S_MUL_HI:
            begin
                // low partial product, rounded half up at bit 24
                acc_reg  <= (TIME_W+1)'(({1'b0, prod_reg} + (2*TIME_W+1)'(1 << (TIME_W-1)))
                                        >> TIME_W);
                prod_reg <= product;
            end
            S_SUM:
                term_reg <= neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
            S_OUT:
            begin
                if (sp_sum > (SLOPE_W+2)'(signed'({1'b0, {(VAL_W-1){1'b1}}})))
                    result_reg.setpoint <= {1'b0, {(VAL_W-1){1'b1}}};
                else if (sp_sum < (SLOPE_W+2)'(signed'({1'b1, {(VAL_W-1){1'b0}}})))
                    result_reg.setpoint <= {1'b1, {(VAL_W-1){1'b0}}};
                else
                    result_reg.setpoint <= sp_sum[VAL_W-1:0];
                result_reg.segment <= seg_reg;
                result_reg.at_end  <= at_end_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_OUT))
        else $error("result strobe without a finished tick");

    a_seg_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        seg_reg <= SEG_MAX)
        else $error("segment index past end of table");

    a_tick_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.mode == MODE_TICK) |=> busy)
        else $error("tick transfer did not start work");

    a_last_seg_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.segment == SEG_MAX) |-> result.at_end)
        else $error("last segment not flagged at end");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SLOPE) |-> $past(state_reg == S_DIV && div_cnt_reg == CNT_LAST))
        else $error("divider left early");

endmodule

[tb/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rsg_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;

    localparam logic [TIME_W-1:0]       TIME_TOP   = '1;
    localparam logic signed [VAL_W-1:0] VAL_TOP    = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_BOTTOM = {1'b1, {(VAL_W-1){1'b0}}};
    localparam longint SLOPE_TOP    = (64'sd1 <<< (SLOPE_W-1)) - 1;
    localparam longint SLOPE_BOTTOM = -(64'sd1 <<< (SLOPE_W-1));

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    rsg_in_t  cmd;
    logic     done;
    rsg_out_t result;

    ramp_soak_setpoint_generator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // profile state as the block should hold it
    logic [TIME_W-1:0]        pt_time [TBL_DEPTH];
    logic signed [VAL_W-1:0]  pt_val  [TBL_DEPTH];
    logic [TIME_W-1:0]        elapsed  = '0;
    logic [SEG_W-1:0]         cur_seg  = '0;
    logic signed [SLOPE_W-1:0] slope   = '0;
    logic [TIME_W-1:0]        anchor_t = '0;
    logic signed [VAL_W-1:0]  anchor_v = '0;

    rsg_out_t pending_setpoints [$];

    int  transfers;
    int  profile_starts;
    int  segment_moves;
    int  setpoints_checked;
    int  mismatches;
    int  idle_cycles;
    bit  allow_gaps;

    function automatic bit segment_is_last(logic [SEG_W-1:0] s);
        if (s >= MAX_STEPS)
            return 1'b1;
        return pt_time[s + 1] <= pt_time[s];
    endfunction

    // slope * d / 2^24, rounded half away from zero
    function automatic longint scale_by_slope(longint s, longint d);
        longint unsigned ms;
        longint unsigned md;
        longint unsigned q;
        bit              neg;
        neg = (s < 0) != (d < 0);
        ms  = (s < 0) ? -s : s;
        md  = (d < 0) ? -d : d;
        q   = (ms >> 24) * md + (((ms & 64'hFF_FFFF) * md + 64'h80_0000) >> 24);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic void predict_setpoint(rsg_in_t it);
        rsg_out_t r;
        longint   dy;
        longint   dt;
        longint   q;
        longint   sp;
        transfers++;
        case (it.mode)
            MODE_WRITE:
            begin
                if (it.point_index <= MAX_STEPS)
                begin
                    pt_time[it.point_index] = it.point_time;
                    pt_val[it.point_index]  = it.point_value;
                end
            end
            MODE_START:
            begin
                pt_val[0] = it.start_value;
                elapsed   = '0;
                cur_seg   = '0;
                slope     = '0;
                anchor_t  = '0;
                anchor_v  = it.start_value;
                profile_starts++;
            end
            MODE_TICK:
            begin
                if (elapsed >= pt_time[cur_seg])
                begin
                    if (!segment_is_last(cur_seg))
                    begin
                        dy = longint'(pt_val[cur_seg + 1]) - longint'(pt_val[cur_seg]);
                        dt = longint'(pt_time[cur_seg + 1]) - longint'(pt_time[cur_seg]);
                        q  = (dy * 64'sd16777216) / dt;
                        if (q > SLOPE_TOP)
                            q = SLOPE_TOP;
                        if (q < SLOPE_BOTTOM)
                            q = SLOPE_BOTTOM;
                        slope    = q[SLOPE_W-1:0];
                        anchor_t = pt_time[cur_seg + 1];
                        anchor_v = pt_val[cur_seg + 1];
                        cur_seg  = cur_seg + 1'b1;
                        segment_moves++;
                    end
                    else
                    begin
                        // last point, or flat or backward next point: hold the current value
                        slope    = '0;
                        anchor_t = pt_time[cur_seg];
                        anchor_v = pt_val[cur_seg];
                    end
                end
                sp = longint'(anchor_v) +
                     scale_by_slope(longint'(slope), longint'(elapsed) - longint'(anchor_t));
                if (sp > longint'(VAL_TOP))
                    sp = longint'(VAL_TOP);
                if (sp < longint'(VAL_BOTTOM))
                    sp = longint'(VAL_BOTTOM);
                r.setpoint = sp[VAL_W-1:0];
                r.segment  = cur_seg;
                r.at_end   = segment_is_last(cur_seg);
                pending_setpoints.push_back(r);
                if (elapsed != TIME_TOP)
                    elapsed = elapsed + 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk)
    begin : check_results
        rsg_out_t want;
        if (rst_n && done)
        begin
            if (pending_setpoints.size() == 0)
            begin
                $error("setpoint strobe with no tick outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_setpoints.pop_front();
                setpoints_checked++;
                if (result.setpoint !== want.setpoint)
                begin
                    $error("setpoint: expected %0d, got %0d", want.setpoint, result.setpoint);
                    mismatches++;
                end
                if (result.segment !== want.segment)
                begin
                    $error("segment: expected %0d, got %0d", want.segment, result.segment);
                    mismatches++;
                end
                if (result.at_end !== want.at_end)
                begin
                    $error("at_end: expected %0d, got %0d", want.at_end, result.at_end);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic rsg_in_t random_item();
        rsg_in_t it;
        it.mode        = mode_t'($urandom_range(0, 3));
        it.point_index = SEG_W'($urandom);
        it.point_time  = TIME_W'($urandom);
        it.point_value = VAL_W'($urandom);
        it.start_value = VAL_W'($urandom);
        return it;
    endfunction

    function automatic logic signed [VAL_W-1:0] random_value();
        if ($urandom_range(0, 3) == 0)
            return VAL_W'($urandom);
        return VAL_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
    endfunction

    // called just after a falling edge; returns just after a falling edge
    task automatic send_item(rsg_in_t it);
        start <= 1'b1;
        cmd   <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_setpoint(it);
        @(negedge clk);
        if (allow_gaps && $urandom_range(0, 4) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13))
                @(negedge clk);
        end
    endtask

    task automatic write_point(int idx, logic [TIME_W-1:0] t, logic signed [VAL_W-1:0] v);
        rsg_in_t it;
        it             = random_item();
        it.mode        = MODE_WRITE;
        it.point_index = SEG_W'(idx);
        it.point_time  = t;
        it.point_value = v;
        send_item(it);
    endtask

    task automatic start_profile(logic signed [VAL_W-1:0] v);
        rsg_in_t it;
        it             = random_item();
        it.mode        = MODE_START;
        it.start_value = v;
        send_item(it);
    endtask

    task automatic tick();
        rsg_in_t it;
        it      = random_item();
        it.mode = MODE_TICK;
        send_item(it);
    endtask

    task automatic send_unused_mode();
        rsg_in_t it;
        it      = random_item();
        it.mode = mode_t'(MODE_UNUSED);
        send_item(it);
    endtask

    // fills every table entry, so no tick ever reads an unwritten point
    task automatic build_profile(output int ticks);
        logic [TIME_W-1:0] times [TBL_DEPTH];
        int                style;
        int                rot;
        int                idx;
        style = $urandom_range(0, 7);
        rot   = $urandom_range(0, MAX_STEPS);
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            case (style)
                0: times[i] = (i == 0) ? '0 : TIME_W'($urandom);
                1: times[i] = (i == 0) ? TIME_W'($urandom) : times[i - 1] + 1'b1;
                default:
                begin
                    if (i == 0)
                        times[i] = TIME_W'($urandom_range(0, 3));
                    else if ($urandom_range(0, 39) == 0)
                        times[i] = times[i - 1] - TIME_W'($urandom_range(0, 2));
                    else
                        times[i] = times[i - 1] + TIME_W'($urandom_range(1, 4));
                end
            endcase
        end
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            idx = (i + rot) % TBL_DEPTH;
            write_point(idx, times[idx], random_value());
        end
        if (style >= 2)
            ticks = (times[MAX_STEPS] > 90 ? 90 : int'(times[MAX_STEPS])) +
                    $urandom_range(1, 6);
        else
            ticks = $urandom_range(3, 12);
    endtask

    task automatic test_table_extremes();
        logic [TIME_W-1:0] t;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            // point four repeats point three's time, point sixteen sits at the last tick
            t = (i == 4) ? TIME_W'(3) : (i == MAX_STEPS) ? TIME_TOP : TIME_W'(i);
            write_point(i, t, (i % 2) ? VAL_TOP : VAL_BOTTOM);
        end
        // tick straight out of reset, before any profile start
        tick();
    endtask

    task automatic test_ignored_items();
        write_point(MAX_STEPS + 1, '0, VAL_TOP);
        write_point((1 << SEG_W) - 1, TIME_TOP, VAL_BOTTOM);
        send_unused_mode();
        tick();
    endtask

    task automatic test_hold_and_saturation();
        start_profile(VAL_TOP);
        repeat (5)
            tick();
    endtask

    task automatic test_longest_segment();
        write_point(1, TIME_TOP, VAL_TOP);
        start_profile(VAL_BOTTOM);
        repeat (2)
            tick();
    endtask

    task automatic run_clean_profile();
        int ticks;
        logic signed [VAL_W-1:0] v;
        build_profile(ticks);
        case ($urandom_range(0, 7))
            0: v = VAL_TOP;
            1: v = VAL_BOTTOM;
            default: v = random_value();
        endcase
        start_profile(v);
        repeat (ticks)
            tick();
    endtask

    task automatic test_profile_runs();
        repeat (14)
            run_clean_profile();
    endtask

    task automatic test_disturbed_profiles();
        int ticks;
        repeat (4)
        begin
            build_profile(ticks);
            start_profile(random_value());
            for (int k = 0; k < ticks; k++)
            begin
                case ($urandom_range(0, 9))
                    0: send_unused_mode();
                    1: write_point($urandom_range(MAX_STEPS + 1, (1 << SEG_W) - 1),
                                   TIME_W'($urandom), random_value());
                    2: write_point($urandom_range(0, MAX_STEPS), TIME_W'($urandom),
                                   random_value());
                    3: start_profile(random_value());
                    4: send_item(random_item());
                    default: tick();
                endcase
            end
        end
    endtask

    task automatic test_back_to_back();
        allow_gaps = 1'b0;
        repeat (2)
            run_clean_profile();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        allow_gaps = 1'b1;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_table_extremes();
        test_ignored_items();
        test_hold_and_saturation();
        test_longest_segment();
        test_profile_runs();
        test_disturbed_profiles();
        test_back_to_back();

        start <= 1'b0;
        while (pending_setpoints.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("%0d command transfers over %0d profile starts, %0d segment moves",
                 transfers, profile_starts, segment_moves);
        $display("%0d setpoint results compared, %0d field mismatches",
                 setpoints_checked, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
hdl/rsg_pkg.sv
hdl/ramp_soak_setpoint_generator.sv
tb/tb_top.sv
